// ----- sv/pshm_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the path string mix hash.
package pshm_pkg;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = $clog2(QDEPTH);

    localparam logic [31:0] KEY_INIT     = 32'hF4FA8928;
    localparam logic [31:0] STATE_INIT   = 32'h37A8470E;
    localparam logic [31:0] TWEAK_INIT   = 32'h7758B42B;
    localparam logic [31:0] FIXED_WORD_A = 32'h9BE74448;
    localparam logic [31:0] FIXED_WORD_B = 32'h66F42C48;
    localparam logic [31:0] KEY_XOR      = 32'h267B0B11;
    localparam logic [31:0] S_OR_MASK    = 32'h02040801;
    localparam logic [31:0] S_AND_MASK   = 32'hBFEF7FDF;
    localparam logic [31:0] T_OR_MASK    = 32'h00804021;
    localparam logic [31:0] T_AND_MASK   = 32'h7DFEFBFF;

    localparam logic [7:0] UPPER_A = 8'h41;
    localparam logic [7:0] UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    // One queued request from the front to the mixing engine.
    typedef struct packed {
        logic [31:0] word;
        logic        has_word;
        logic        fin;
    } t_cmd;

    typedef enum logic [2:0] {
        B_IDLE,
        B_OPER,
        B_MULT,
        B_CORR,
        B_EMIT
    } t_bstate;

    typedef enum logic [1:0] {
        STEP_DATA,
        STEP_FIX_A,
        STEP_FIX_B
    } t_step;

endpackage

// ----- sv/pshm_front.sv -----
`timescale 1ns / 1ps
// Front end: case folding, little-endian word packing and end-of-string requests.
module pshm_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_data_byte,
    input  logic               i_byte_valid,
    input  logic               i_last,
    output logic               o_push,
    output pshm_pkg::t_cmd     o_cmd,
    input  logic               i_full
);
    import pshm_pkg::*;

    logic [23:0] r_pend;
    logic [1:0]  r_cnt;
    logic [23:0] n_pend;
    logic [1:0]  n_cnt;

    logic        accept;
    logic [7:0]  folded;
    logic [31:0] merged;
    logic [1:0]  cnt_inc;
    logic        full_word;

    assign o_in_ready = !i_full;
    assign accept     = i_in_valid && !i_full;

    always_comb begin
        folded = i_data_byte;
        if (i_data_byte >= UPPER_A && i_data_byte <= UPPER_Z) begin
            folded = i_data_byte + CASE_OFFSET;
        end
        if (i_byte_valid) begin
            merged  = {8'h00, r_pend} | ({24'h000000, folded} << {r_cnt, 3'b000});
            cnt_inc = r_cnt + 2'd1;
        end else begin
            merged  = {8'h00, r_pend};
            cnt_inc = r_cnt;
        end
        full_word = i_byte_valid && (r_cnt == 2'd3);

        // A request goes out for every completed word and for every end of string.
        o_push         = accept && (full_word || i_last);
        o_cmd.word     = merged;
        o_cmd.has_word = full_word || (cnt_inc != 2'd0);
        o_cmd.fin      = i_last;

        n_pend = r_pend;
        n_cnt  = r_cnt;
        if (accept) begin
            if (i_last || full_word) begin
                n_pend = '0;
                n_cnt  = '0;
            end else begin
                n_pend = merged[23:0];
                n_cnt  = cnt_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_cnt  <= '0;
        end else begin
            r_pend <= n_pend;
            r_cnt  <= n_cnt;
        end
    end

endmodule

// ----- sv/pshm_fifo.sv -----
`timescale 1ns / 1ps
// Short request queue between the front end and the mixing engine.
module pshm_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  pshm_pkg::t_cmd     i_cmd,
    output logic               o_full,
    input  logic               i_pop,
    output pshm_pkg::t_cmd     o_cmd,
    output logic               o_empty
);
    import pshm_pkg::*;

    t_cmd             r_mem [QDEPTH];
    logic [QAW-1:0]   r_wptr;
    logic [QAW-1:0]   r_rptr;
    logic [QAW:0]     r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == QAW'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == QAW'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- sv/pshm_back.sv -----
`timescale 1ns / 1ps
// Mixing engine: word rounds (operand setup, multiply, carry correction), fixed-word tail and hash output register.
module pshm_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pshm_pkg::t_cmd     i_cmd,
    input  logic               i_empty,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [31:0]        o_hash_value
);
    import pshm_pkg::*;

    t_bstate     r_state, n_state;
    t_step       r_step, n_step;
    logic        r_fin, n_fin;
    logic [31:0] r_word, n_word;
    logic [31:0] r_key, n_key;
    logic [31:0] r_mix_s, n_mix_s;
    logic [31:0] r_mix_t, n_mix_t;
    logic [31:0] r_b, n_b;
    logic [31:0] r_c, n_c;
    logic [63:0] r_p1, r_p2;
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_hash, n_hash;

    logic [31:0] key_rot;
    logic [31:0] e_val;
    logic [31:0] s_x;
    logic [31:0] t_x;
    logic [31:0] s_a1;
    logic [32:0] s_sum;
    logic [31:0] s_new;
    logic [32:0] t_dbl;
    logic [31:0] t_a1;
    logic [32:0] t_sum;
    logic [31:0] t_new;

    assign o_out_valid  = r_out_valid;
    assign o_hash_value = r_hash;

    // End-around carry corrections on the registered products.
    always_comb begin
        s_a1  = r_p1[31:0] + {31'd0, (r_p1[63:32] != 32'd0)};
        s_sum = {1'b0, s_a1} + {1'b0, r_p1[63:32]};
        s_new = s_sum[31:0] + {31'd0, s_sum[32]};

        // The high half is doubled before it is folded into the low half.
        t_dbl = {r_p2[63:32], 1'b0};
        t_a1  = r_p2[31:0] + {31'd0, t_dbl[32]};
        t_sum = {1'b0, t_a1} + {1'b0, t_dbl[31:0]};
        t_new = t_sum[31:0] + {30'd0, t_sum[32], 1'b0};
    end

    always_comb begin
        key_rot = {r_key[30:0], r_key[31]};
        e_val   = KEY_XOR ^ key_rot;
        s_x     = r_mix_s ^ r_word;
        t_x     = r_mix_t ^ r_word;

        n_state     = r_state;
        n_step      = r_step;
        n_fin       = r_fin;
        n_word      = r_word;
        n_key       = r_key;
        n_mix_s     = r_mix_s;
        n_mix_t     = r_mix_t;
        n_b         = r_b;
        n_c         = r_c;
        n_out_valid = r_out_valid;
        n_hash      = r_hash;
        o_pop       = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_fin   = i_cmd.fin;
                    n_state = B_OPER;
                    if (i_cmd.has_word) begin
                        n_word = i_cmd.word;
                        n_step = STEP_DATA;
                    end else begin
                        n_word = FIXED_WORD_A;
                        n_step = STEP_FIX_A;
                    end
                end
            end
            B_OPER: begin
                n_key   = key_rot;
                n_mix_s = s_x;
                n_mix_t = t_x;
                n_b     = ((e_val + t_x) | S_OR_MASK) & S_AND_MASK;
                n_c     = ((e_val + s_x) | T_OR_MASK) & T_AND_MASK;
                n_state = B_MULT;
            end
            B_MULT: begin
                n_state = B_CORR;
            end
            B_CORR: begin
                n_mix_s = s_new;
                n_mix_t = t_new;
                if (!r_fin) begin
                    n_state = B_IDLE;
                end else begin
                    case (r_step)
                        STEP_DATA: begin
                            n_word  = FIXED_WORD_A;
                            n_step  = STEP_FIX_A;
                            n_state = B_OPER;
                        end
                        STEP_FIX_A: begin
                            n_word  = FIXED_WORD_B;
                            n_step  = STEP_FIX_B;
                            n_state = B_OPER;
                        end
                        default: begin
                            n_state = B_EMIT;
                        end
                    endcase
                end
            end
            B_EMIT: begin
                // Wait for a free output slot, then start the next string from scratch.
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_hash      = r_mix_s ^ r_mix_t;
                    n_key       = KEY_INIT;
                    n_mix_s     = STATE_INIT;
                    n_mix_t     = TWEAK_INIT;
                    n_state     = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_step      <= STEP_DATA;
            r_fin       <= 1'b0;
            r_key       <= KEY_INIT;
            r_mix_s     <= STATE_INIT;
            r_mix_t     <= TWEAK_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_fin       <= n_fin;
            r_key       <= n_key;
            r_mix_s     <= n_mix_s;
            r_mix_t     <= n_mix_t;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_b    <= n_b;
        r_c    <= n_c;
        r_hash <= n_hash;
        if (r_state == B_MULT) begin
            r_p1 <= 64'(r_b) * 64'(r_mix_s);
            r_p2 <= 64'(r_mix_t) * 64'(r_c);
        end
    end

endmodule

// ----- sv/path_string_mix_hash_top.sv -----
`timescale 1ns / 1ps
// Top level of the path string mix hash.
//
// Input channel (i_in_valid / o_in_ready) carries one request per cycle: a byte,
// a flag that says whether the byte belongs to the string, and an end-of-string
// flag. Letters A-Z are folded to lower case and packed four to a word.
// Output channel (o_out_valid / i_out_ready) carries one 32-bit hash per string.
// The front end takes one request every cycle while the four-entry queue has room.
// The mixing engine handles each word in four steps (queue pop, operand setup,
// two parallel 32x32 multiplies, carry correction), so a steady byte stream is
// absorbed at one byte per cycle. An end-of-string request adds two rounds for
// the fixed words and an output step, after a round for any last word that
// still has to be mixed.
// When the receiver stalls, the finished hash stays in the output register and
// the queue keeps filling; o_in_ready drops only once the queue is full.
// Reset clears the partial word, the queue, the output and loads the mixing
// registers with their seed values.
module path_string_mix_hash_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_valid,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_hash_value
);
    import pshm_pkg::*;

    logic push;
    logic full;
    logic pop;
    logic empty;
    t_cmd cmd_in;
    t_cmd cmd_out;

    pshm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_byte  (i_data_byte),
        .i_byte_valid (i_byte_valid),
        .i_last       (i_last),
        .o_push       (push),
        .o_cmd        (cmd_in),
        .i_full       (full)
    );

    pshm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_cmd   (cmd_out),
        .o_empty (empty)
    );

    pshm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_out),
        .i_empty      (empty),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_hash_value (o_hash_value)
    );

endmodule
